// File: hw/rtl/value_noise_turbulence_core_defines.svh
// Assertion macros for the checker file of the noise core.
// Depends on nothing; include by bare file name.
`ifndef VALUE_NOISE_TURBULENCE_CORE_DEFINES_SVH
`define VALUE_NOISE_TURBULENCE_CORE_DEFINES_SVH
// Check an implication on every clock edge outside reset.
`define VNT_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Check an implication in the next cycle.
`define VNT_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

// File: hw/rtl/vnt_pkg.sv
// Package of the value noise core: table sizes, codes and state types.
// Depends on nothing.
`default_nettype none
package vnt_pkg;
   localparam int TableSize  = 256;
   localparam int IdxBits    = $clog2(TableSize);
   localparam int FracBits   = 16;
   localparam int MaxOctaves = 8;
   localparam int OctBits    = $clog2(MaxOctaves + 1);
   localparam int AccBits    = FracBits + MaxOctaves + 1;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0, ACT_NOISE = 2'd1, ACT_TURB = 2'd2, ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      SEL_VALUE = 2'd0, SEL_PERM_X = 2'd1, SEL_PERM_Y = 2'd2, SEL_PERM_Z = 2'd3
   } select_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SMOOTH, ST_SQ, ST_SMUL, ST_PADDR, ST_PWAIT, ST_VADDR,
      ST_VWAIT, ST_LERP_A, ST_LERP_B, ST_ACCUM, ST_DONE
   } state_type;
endpackage
`default_nettype wire

// File: hw/rtl/vnt_mul.sv
// Shared unsigned multiplier of the noise core, one registered product.
// Depends on vnt_pkg.
`default_nettype none
module vnt_mul (
   input  wire logic        clock,
   input  wire logic [17:0] a_in,
   input  wire logic [17:0] b_in,
   output logic      [35:0] p_ff
);
   import vnt_pkg::*;
   logic [35:0] p_in;
   // form one product per cycle
   assign p_in = a_in * b_in;
   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end
endmodule
`default_nettype wire

// File: hw/rtl/value_noise_turbulence_core.sv
// Value noise core: 3D lattice value noise and turbulence, sequential.
// Depends on vnt_pkg and vnt_mul.
//
// Usage: an item on req_ is accepted when req_valid is high and req_stall
// low. Action write stores one table entry and gives no result.
// Noise and turbulence items each give one rsp_ item carrying
// rsp_noise_value. Tables must be loaded before noise is evaluated.
// Sequence: each octave runs on the shared multiplier and the single table
// read port: smoothing per axis (square, multiply by 3 - 2f, keep), then
// for each of 8 corners 3 permutation reads and one value read, then 7
// interpolations. A noise item runs one octave and a turbulence item n
// octaves (octave_count clamped to 8); a turbulence octave count of zero
// answers 0. The next item can be taken once the result leaves the
// sequencer. A waiting result sits in the output register, so the block
// takes the next item meanwhile; a finished result waits inside until the
// register is free. rsp_valid holds until rsp_stall is low. Reset clears
// the control state and sets octave_count to 7; table contents stay
// undefined until written. csr_ writes are taken at any edge outside reset
// when csr_write is high.
`default_nettype none
module value_noise_turbulence_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [3:0]  csr_octave_count,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [1:0]  req_table_select,
   input  wire logic [7:0]  req_table_index,
   input  wire logic [15:0] req_table_value,
   input  wire logic signed [31:0] req_px,
   input  wire logic signed [31:0] req_py,
   input  wire logic signed [31:0] req_pz,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [16:0]      rsp_noise_value
);
   import vnt_pkg::*;

   // tables
   logic [15:0]        val_mem [TableSize];
   logic [IdxBits-1:0] perm_mem [3][TableSize];

   state_type  state_ff, state_in;
   logic [3:0] oct_cfg_ff;
   logic [31:0] pt_ff [3], pt_in [3];
   logic [1:0]  ax_ff, ax_in;
   logic [2:0]  cor_ff, cor_in;
   logic [OctBits-1:0] oct_ff, oct_in, oct_lim_ff, oct_lim_in;
   logic [FracBits:0]  sm_ff [3], sm_in [3];
   logic [IdxBits-1:0] h_ff, h_in;
   logic [15:0]        rd_ff;
   logic [FracBits:0]  lv_ff [8], lv_in [8];
   logic [35:0]        la_ff, la_in;
   logic [2:0]  lcnt_ff, lcnt_in;
   logic [AccBits-1:0] acc_ff, acc_in;
   logic        rv_ff, rv_in;
   logic [16:0] res_ff, res_in;
   logic [17:0] ma, mb;
   logic [35:0] prod;
   logic [35:0] lsum;
   logic        accept;
   logic [1:0]  rsel;
   logic [IdxBits-1:0] raddr;
   logic        vrd;
   logic [31:0] cur;
   logic [FracBits-1:0] fr;
   logic [IdxBits-1:0] ibase;
   logic        cbit;
   logic [2:0]  ia, ib;
   logic [FracBits:0] tw;

   vnt_mul u_mul (.clock(clock), .a_in(ma), .b_in(mb), .p_ff(prod));

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_noise_value = res_ff;

   // write tables, read one entry per cycle
   always_ff @(posedge clock) begin
      if (accept && req_action == ACT_WRITE) begin
         if (req_table_select == SEL_VALUE)
            val_mem[req_table_index[IdxBits-1:0]] <= req_table_value;
         else
            perm_mem[req_table_select - 2'd1][req_table_index[IdxBits-1:0]]
               <= req_table_value[IdxBits-1:0];
      end
      if (vrd) rd_ff <= val_mem[raddr];
      else     rd_ff <= {{(16-IdxBits){1'b0}}, perm_mem[rsel][raddr]};
   end

   // register state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff <= 1'b0;
         oct_cfg_ff <= 4'd7;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
         if (csr_write) oct_cfg_ff <= csr_octave_count;
      end
      pt_ff <= pt_in; ax_ff <= ax_in; cor_ff <= cor_in; oct_ff <= oct_in;
      oct_lim_ff <= oct_lim_in; sm_ff <= sm_in; h_ff <= h_in;
      lv_ff <= lv_in; la_ff <= la_in; lcnt_ff <= lcnt_in; acc_ff <= acc_in;
      res_ff <= res_in;
   end

   // advance the sequencer
   always_comb begin
      state_in = state_ff; pt_in = pt_ff; ax_in = ax_ff; cor_in = cor_ff;
      oct_in = oct_ff; oct_lim_in = oct_lim_ff; sm_in = sm_ff;
      h_in = h_ff; lv_in = lv_ff; la_in = la_ff; lcnt_in = lcnt_ff;
      acc_in = acc_ff; rv_in = rv_ff; res_in = res_ff;
      ma = '0; mb = '0; rsel = 2'd0; raddr = '0; vrd = 1'b0;
      cur = pt_ff[ax_ff];
      fr = cur[FracBits-1:0];
      cbit = (ax_ff == 2'd0) ? cor_ff[2] : (ax_ff == 2'd1) ? cor_ff[1] : cor_ff[0];
      ibase = cur[FracBits +: IdxBits] + {{(IdxBits-1){1'b0}}, cbit};
      // pick the pair for this interpolation: along x, then y, then z
      if (lcnt_ff < 3'd4) begin
         ia = {1'b0, lcnt_ff[1:0]}; ib = ia + 3'd4; tw = sm_ff[0];
      end else if (lcnt_ff < 3'd6) begin
         ia = {2'b0, lcnt_ff[0]}; ib = ia + 3'd2; tw = sm_ff[1];
      end else begin
         ia = 3'd0; ib = 3'd1; tw = sm_ff[2];
      end
      // full-precision a*(1-t) + b*t
      lsum = la_ff + prod;
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_action == ACT_NOISE || req_action == ACT_TURB)) begin
               pt_in[0] = req_px; pt_in[1] = req_py; pt_in[2] = req_pz;
               ax_in = 2'd0; oct_in = '0; acc_in = '0;
               if (req_action == ACT_NOISE) oct_lim_in = OctBits'(1);
               else if (oct_cfg_ff > 4'(MaxOctaves)) oct_lim_in = OctBits'(MaxOctaves);
               else oct_lim_in = OctBits'(oct_cfg_ff);
               state_in = ST_SMOOTH;
               if (req_action == ACT_TURB && oct_cfg_ff == 4'd0) state_in = ST_DONE;
            end
         end
         ST_SMOOTH: begin
            // square the fraction
            ma = {2'b0, fr}; mb = {2'b0, fr};
            state_in = ST_SQ;
         end
         ST_SQ: begin
            // multiply the square by 3 - 2f
            ma = {1'b0, prod[FracBits +: FracBits+1]};
            mb = 18'((3 << FracBits) - (32'(fr) << 1));
            state_in = ST_SMUL;
         end
         ST_SMUL: begin
            // keep the smoothed weight, move to the next axis
            sm_in[ax_ff] = prod[FracBits +: FracBits+1];
            if (ax_ff == 2'd2) begin
               ax_in = 2'd0; cor_in = '0; state_in = ST_PADDR;
            end else begin
               ax_in = ax_ff + 2'd1; state_in = ST_SMOOTH;
            end
         end
         ST_PADDR: begin
            // read permutation entry for the current axis
            rsel = ax_ff; raddr = ibase;
            state_in = ST_PWAIT;
         end
         ST_PWAIT: begin
            h_in = ((ax_ff == 2'd0) ? '0 : h_ff) ^ rd_ff[IdxBits-1:0];
            if (ax_ff == 2'd2) begin
               ax_in = 2'd0; state_in = ST_VADDR;
            end else begin
               ax_in = ax_ff + 2'd1; state_in = ST_PADDR;
            end
         end
         ST_VADDR: begin
            vrd = 1'b1; raddr = h_ff;
            state_in = ST_VWAIT;
         end
         ST_VWAIT: begin
            lv_in[cor_ff] = {1'b0, rd_ff};
            if (cor_ff == 3'd7) begin
               cor_in = '0; lcnt_in = '0; state_in = ST_LERP_A;
            end else begin
               cor_in = cor_ff + 3'd1; state_in = ST_PADDR;
            end
         end
         ST_LERP_A: begin
            // a*(1-t)
            ma = {1'b0, lv_ff[ia]};
            mb = 18'(32'(1 << FracBits) - 32'(tw));
            state_in = ST_LERP_B;
         end
         ST_LERP_B: begin
            // hold a*(1-t), form b*t
            la_in = prod;
            ma = {1'b0, lv_ff[ib]}; mb = {1'b0, tw};
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            lv_in[ia] = lsum[FracBits +: FracBits+1];
            lcnt_in = lcnt_ff + 3'd1;
            state_in = ST_LERP_A;
            if (lcnt_ff == 3'd6) begin
               // add the octave, double the point
               acc_in = acc_ff + (AccBits'(lsum[FracBits +: FracBits+1])
                        << (MaxOctaves - 1 - oct_ff));
               oct_in = oct_ff + 1'b1;
               for (int i = 0; i < 3; i++) pt_in[i] = pt_ff[i] << 1;
               ax_in = 2'd0; cor_in = '0;
               if (oct_ff + 1'b1 == oct_lim_ff) state_in = ST_DONE;
               else state_in = ST_SMOOTH;
            end
         end
         ST_DONE: begin
            // move the result out once the output register is free
            if (!rv_ff || !rsp_stall) begin
               rv_in = 1'b1;
               res_in = 17'(acc_ff >> (MaxOctaves - 1));
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// File: hw/rtl/vnt_checker.sv
// Port checker for the value noise core, bound to the top level.
// Depends on the defines header.
`default_nettype none
`include "value_noise_turbulence_core_defines.svh"
module vnt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [16:0] rsp_noise_value
);
   // a waiting result holds
   `VNT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_noise_value))
   // an offered item always sees a known stall
   `VNT_ASSERT_IMPL(a_known_stall, clock, reset, req_valid, !$isunknown(req_stall))
   // a result item carries known bits
   `VNT_ASSERT_IMPL(a_known_rsp, clock, reset, rsp_valid, !$isunknown(rsp_noise_value))
   // results appear only after a stall period
   `VNT_ASSERT_IMPL(a_rsp_rise, clock, reset, $rose(rsp_valid), $past(req_stall))
endmodule
bind value_noise_turbulence_core vnt_checker u_vnt_checker (.*);
`default_nettype wire

// File: test/tb_top.sv
// Testbench of value_noise_turbulence_core: lattice noise and turbulence checked
// against a predictor of its own. Depends on vnt_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_top;
   import vnt_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [3:0]  csr_octave_count = 4'd0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = ACT_NONE;
   logic [1:0]  req_table_select = SEL_VALUE;
   logic [7:0]  req_table_index = 8'd0;
   logic [15:0] req_table_value = 16'd0;
   logic [31:0] req_px = 32'd0;
   logic [31:0] req_py = 32'd0;
   logic [31:0] req_pz = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [16:0] rsp_noise_value;

   value_noise_turbulence_core dut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_octave_count(csr_octave_count),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_action(req_action), .req_table_select(req_table_select),
      .req_table_index(req_table_index), .req_table_value(req_table_value),
      .req_px(req_px), .req_py(req_py), .req_pz(req_pz),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_noise_value(rsp_noise_value)
   );

   localparam int DrainCycles = 600;
   localparam int HoldCycles  = 2000;

   // Predictor state: tables and octave setting as the block should hold them
   logic [15:0] value_tab [TableSize];
   logic [7:0]  perm_x_tab [TableSize];
   logic [7:0]  perm_y_tab [TableSize];
   logic [7:0]  perm_z_tab [TableSize];
   logic [3:0]  octaves_set = 4'd7;

   logic [16:0] expected_noise [$];
   int          mismatches = 0;
   bit          quiet_sender = 1'b0;
   bit          quiet_receiver = 1'b0;
   bit          hold_request = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] smooth_frac(logic [31:0] c);
      logic [63:0] f, sq;
      f  = {48'd0, c[15:0]};
      sq = (f * f) >> FracBits;
      return (sq * (64'd3 * 64'd65536 - 64'd2 * f)) >> FracBits;
   endfunction

   function automatic logic [63:0] blend(logic [63:0] a, logic [63:0] b, logic [63:0] t);
      return (a * (64'd65536 - t) + b * t) >> FracBits;
   endfunction

   function automatic logic [63:0] lattice_noise(logic [31:0] x, logic [31:0] y,
                                                 logic [31:0] z);
      logic [63:0] corner [8];
      logic [63:0] u, v, w, y00, y10, y01, y11, z0, z1;
      logic [7:0]  h, ix, iy, iz;
      ix = x[23:16];
      iy = y[23:16];
      iz = z[23:16];
      for (int n = 0; n < 8; n++) begin
         h = perm_x_tab[8'(ix + n[2])] ^ perm_y_tab[8'(iy + n[1])]
             ^ perm_z_tab[8'(iz + n[0])];
         corner[n] = {48'd0, value_tab[h]};
      end
      u = smooth_frac(x);
      v = smooth_frac(y);
      w = smooth_frac(z);
      // corner index is {dx, dy, dz}
      y00 = blend(corner[0], corner[4], u);
      y10 = blend(corner[2], corner[6], u);
      y01 = blend(corner[1], corner[5], u);
      y11 = blend(corner[3], corner[7], u);
      z0  = blend(y00, y10, v);
      z1  = blend(y01, y11, v);
      return blend(z0, z1, w);
   endfunction

   function automatic logic [16:0] turbulence_sum(logic [31:0] x, logic [31:0] y,
                                                  logic [31:0] z);
      logic [63:0] acc;
      int          count;
      acc   = 64'd0;
      count = (octaves_set > MaxOctaves) ? MaxOctaves : octaves_set;
      for (int k = 0; k < count; k++) begin
         acc += lattice_noise(x, y, z) << (MaxOctaves - 1 - k);
         x = x << 1;
         y = y << 1;
         z = z << 1;
      end
      return 17'(acc >> (MaxOctaves - 1));
   endfunction

   // Check each result item against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_noise.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result item %h", rsp_noise_value);
         end else begin
            if (rsp_noise_value !== expected_noise[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("noise_value mismatch: expected %h actual %h",
                           expected_noise[0], rsp_noise_value);
            end
            void'(expected_noise.pop_front());
         end
      end
   end

   // Receiver: random stalls, calm stretches and one long hold-off
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(negedge clock);
            hold_request = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= !quiet_receiver && ($urandom_range(99) < 36);
         end
      end
   end

   // Offer one item, wait for it to be taken, then predict what it causes
   task automatic send_item(action_type act, select_type sel, logic [7:0] idx,
                            logic [15:0] val, logic [31:0] x, logic [31:0] y,
                            logic [31:0] z);
      @(negedge clock);
      while (!quiet_sender && $urandom_range(99) < 36) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_action = act;
      req_table_select = sel;
      req_table_index = idx;
      req_table_value = val;
      req_px = x;
      req_py = y;
      req_pz = z;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      case (act)
         ACT_WRITE: begin
            case (sel)
               SEL_VALUE:  value_tab[idx] = val;
               SEL_PERM_X: perm_x_tab[idx] = val[7:0];
               SEL_PERM_Y: perm_y_tab[idx] = val[7:0];
               default:    perm_z_tab[idx] = val[7:0];
            endcase
         end
         ACT_NOISE: expected_noise.push_back(17'(lattice_noise(x, y, z)));
         ACT_TURB:  expected_noise.push_back(turbulence_sum(x, y, z));
         default: ;
      endcase
   endtask

   // Hold until every expected result has come and the block is quiet
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_noise.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic set_octaves(logic [3:0] n);
      drain_results();
      @(negedge clock);
      csr_octave_count = n;
      csr_write = 1'b1;
      @(negedge clock);
      csr_write = 1'b0;
      octaves_set = n;
   endtask

   task automatic send_random_point(action_type act);
      logic [31:0] x, y, z;
      x = $urandom();
      y = $urandom();
      z = $urandom();
      // keep some points near the origin so neighboring cells repeat
      if ($urandom_range(1)) begin
         x = {{8{x[31]}}, x[23:0]};
         y = {{8{y[31]}}, y[23:0]};
         z = {{8{z[31]}}, z[23:0]};
      end
      send_item(act, select_type'($urandom_range(3)), 8'($urandom()),
                16'($urandom()), x, y, z);
   endtask

   // Load every entry of all four tables; permutations carry junk upper bits
   task automatic test_table_load();
      for (int s = 0; s < 4; s++)
         for (int i = 0; i < TableSize; i++)
            send_item(ACT_WRITE, select_type'(s), 8'(i), 16'($urandom()),
                      $urandom(), $urandom(), $urandom());
   endtask

   task automatic test_point_extremes();
      send_item(ACT_NOISE, SEL_VALUE, 8'd0, 16'd0, 32'h0, 32'h0, 32'h0);
      send_item(ACT_NOISE, SEL_VALUE, 8'd0, 16'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF);
      send_item(ACT_NOISE, SEL_VALUE, 8'd0, 16'd0, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000);
      send_item(ACT_NOISE, SEL_VALUE, 8'd0, 16'd0, 32'h0000_FFFF, 32'hFFFF_FFFF,
                32'h00FF_8000);
      send_item(ACT_NOISE, SEL_VALUE, 8'd0, 16'd0, 32'hFFFF_0000, 32'h0001_0000,
                32'h00FF_FFFF);
      send_item(ACT_TURB, SEL_VALUE, 8'd0, 16'd0, 32'h7FFF_FFFF, 32'hC000_0001,
                32'h8000_0000);
      // set the last entry of each table, then take turbulence at the top corner
      send_item(ACT_WRITE, SEL_VALUE, 8'd255, 16'hFFFF, 32'h0, 32'h0, 32'h0);
      send_item(ACT_WRITE, SEL_PERM_X, 8'd255, 16'hFFFF, 32'h0, 32'h0, 32'h0);
      send_item(ACT_WRITE, SEL_PERM_Y, 8'd255, 16'hFF00, 32'h0, 32'h0, 32'h0);
      send_item(ACT_WRITE, SEL_PERM_Z, 8'd255, 16'h00FF, 32'h0, 32'h0, 32'h0);
      send_item(ACT_TURB, SEL_VALUE, 8'd0, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF);
   endtask

   // Zero, one, the maximum and a count that saturates
   task automatic test_octave_limits();
      logic [3:0] counts [4] = '{4'd0, 4'd1, 4'd8, 4'd15};
      foreach (counts[c]) begin
         set_octaves(counts[c]);
         send_item(ACT_TURB, SEL_VALUE, 8'd0, 16'd0, 32'h1234_5678, 32'h8765_4321,
                   32'hFFFF_8000);
         send_random_point(ACT_TURB);
      end
   endtask

   // Unused action must leave no result and no trace
   task automatic test_ignored_action();
      send_item(ACT_NONE, SEL_VALUE, 8'd0, 16'hFFFF, 32'h0, 32'h0, 32'h0);
      send_item(ACT_NOISE, SEL_VALUE, 8'd0, 16'd0, 32'h0001_8000, 32'h0, 32'h0);
   endtask

   // Receiver holds off while items keep coming, then the sender drains
   task automatic test_backpressure();
      drain_results();
      hold_request = 1'b1;
      repeat (8) send_random_point(ACT_NOISE);
      repeat (4) send_random_point(ACT_WRITE);
      drain_results();
   endtask

   task automatic test_random_mix();
      int          pick;
      logic [3:0]  phase_counts [5] = '{4'd3, 4'd15, 4'd1, 4'd0, 4'd5};
      foreach (phase_counts[p]) begin
         set_octaves(p == 4 ? 4'($urandom_range(15)) : phase_counts[p]);
         quiet_sender = (p == 2);
         quiet_receiver = (p == 2);
         for (int i = 0; i < 165; i++) begin
            pick = $urandom_range(99);
            if (pick < 38)      send_random_point(ACT_NOISE);
            else if (pick < 76) send_random_point(ACT_TURB);
            else if (pick < 93) send_random_point(ACT_WRITE);
            else begin
               send_random_point(ACT_NONE);
               i--;
            end
            if (i == 80) drain_results();
         end
      end
      quiet_sender = 1'b0;
      quiet_receiver = 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_table_load();
      test_point_extremes();
      test_ignored_action();
      test_octave_limits();
      test_backpressure();
      test_random_mix();
      drain_results();
      if (mismatches == 0 && expected_noise.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      #60ms;
      $display("tb_top: FAIL");
      $finish;
   end
endmodule
